>>> hw/rtl/pows_pkg.sv
// Shared types and constants for the pulse oscillator width sweep unit.
// Depends on nothing; imported by pulse_oscillator_width_sweep_unit.
package pows_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int WIDTH_BITS  = 10;
   localparam int STEP_BITS   = $clog2(COUNT_BITS);
   localparam int WIDTH_RESET = 100;

   typedef struct packed {
      logic [7:0]  period;
      logic [9:0]  target_width;
      logic [9:0]  start_width;
      logic [15:0] step_interval;
      logic        trigger;
   } pows_req_type;

   typedef struct packed {
      logic       level;
      logic [9:0] width_now;
   } pows_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PERIOD,
      ST_SWEEP,
      ST_WIDTH,
      ST_FINISH
   } pows_state_type;

endpackage

>>> hw/rtl/pulse_oscillator_width_sweep_unit.sv
// Pulse oscillator with pulse-width sweep: top level and its sequencer.
// Depends on pows_pkg (types, counter and width sizes, state codes).
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): one word per audio tick,
//    carrying period, target and start width, sweep step interval, trigger.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): one word per tick with the
//    square wave level and the pulse width after that tick.
//  - The three "is a multiple of" tests share one restoring remainder unit
//    that retires one dividend bit per cycle; they run one after another:
//    period test, sweep test, width test, and then the finish state loads
//    the result word. req_ready is low from acceptance until the sequencer
//    is back in the idle state, so a new tick waits for the last to finish.
//  - Results sit in an output register. The next tick is accepted while a
//    finished word still waits; a tick that finishes while the register is
//    still full waits in the finish state until rsp_ready frees it.
//  - Reset (synchronous, active high) clears the counters, drops the level,
//    loads a width of 100 and arms the first-tick load of the target width.
//    No result is pending after reset.
module pulse_oscillator_width_sweep_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pows_pkg::pows_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pows_pkg::pows_rsp_type rsp_data
);
   import pows_pkg::*;

   // sequencer and oscillator state
   pows_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]   period_count_ff, period_count_in;
   logic [COUNT_BITS-1:0]   width_count_ff, width_count_in;
   logic [COUNT_BITS-1:0]   sweep_count_ff, sweep_count_in;
   logic                    pulse_active_ff, pulse_active_in;
   logic [WIDTH_BITS-1:0]   cur_width_ff, cur_width_in;
   logic                    level_ff, level_in;
   logic                    first_tick_ff, first_tick_in;

   // fields of the tick in flight needed after acceptance
   logic [WIDTH_BITS-1:0]   target_ff, target_in;
   logic [15:0]             interval_ff, interval_in;

   // shared remainder unit
   logic [COUNT_BITS-1:0]   num_ff, num_in;
   logic [COUNT_BITS-1:0]   den_ff, den_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   pows_rsp_type            rsp_data_ff, rsp_data_in;

   // remainder datapath
   logic [COUNT_BITS:0]     shift_val;
   logic                    shift_ge;
   logic [COUNT_BITS-1:0]   rem_next;
   logic                    div_last;
   logic                    is_mult;

   // tick start values
   logic [WIDTH_BITS-1:0]   req_target;
   logic [WIDTH_BITS-1:0]   start_w;
   logic [COUNT_BITS-1:0]   sweep_base;
   logic [WIDTH_BITS-1:0]   stepped_width;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign shift_val = {rem_ff, num_ff[COUNT_BITS-1]};
   assign shift_ge  = (shift_val >= {1'b0, den_ff});
   assign rem_next  = shift_ge ? COUNT_BITS'(shift_val - {1'b0, den_ff})
                               : shift_val[COUNT_BITS-1:0];
   assign div_last  = (step_ff == STEP_BITS'(COUNT_BITS - 1));
   assign is_mult   = (rem_next == '0);

   assign req_target = WIDTH_BITS'(req_data.target_width);
   assign start_w    = WIDTH_BITS'(req_data.start_width);

   // one sweep step toward the target, for the width test divisor
   always_comb begin
      stepped_width = cur_width_ff;
      if (is_mult) begin
         if (cur_width_ff < target_ff) begin
            stepped_width = cur_width_ff + WIDTH_BITS'(1);
         end else if (cur_width_ff > target_ff) begin
            stepped_width = cur_width_ff - WIDTH_BITS'(1);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      period_count_in = period_count_ff;
      width_count_in  = width_count_ff;
      sweep_count_in  = sweep_count_ff;
      pulse_active_in = pulse_active_ff;
      cur_width_in    = cur_width_ff;
      level_in        = level_ff;
      first_tick_in   = first_tick_ff;
      target_in       = target_ff;
      interval_in     = interval_ff;
      num_in          = num_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      sweep_base      = sweep_count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // divider advances one bit per cycle in every test state
      if (state_ff == ST_PERIOD || state_ff == ST_SWEEP || state_ff == ST_WIDTH) begin
         rem_in  = rem_next;
         num_in  = num_ff << 1;
         step_in = step_ff + STEP_BITS'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in   = req_target;
               interval_in = req_data.step_interval;
               // retrigger only once the previous sweep is finished
               if (req_data.trigger && cur_width_ff == req_target) begin
                  cur_width_in = start_w;
                  sweep_base   = '0;
               end
               if (first_tick_ff) begin
                  cur_width_in  = req_target;
                  first_tick_in = 1'b0;
               end
               period_count_in = period_count_ff + COUNT_BITS'(1);
               width_count_in  = width_count_ff + COUNT_BITS'(1);
               sweep_count_in  = sweep_base + COUNT_BITS'(1);
               num_in  = period_count_ff + COUNT_BITS'(1);
               den_in  = (req_data.period == '0) ? COUNT_BITS'(1)
                                                 : COUNT_BITS'(req_data.period);
               rem_in  = '0;
               step_in = '0;
               state_in = ST_PERIOD;
            end
         end
         ST_PERIOD: begin
            if (div_last) begin
               // pulse start; width counter restarts at one
               if (is_mult && !pulse_active_ff) begin
                  level_in        = 1'b1;
                  pulse_active_in = 1'b1;
                  period_count_in = '0;
                  width_count_in  = COUNT_BITS'(1);
               end
               num_in  = sweep_count_ff;
               den_in  = (interval_ff == '0) ? COUNT_BITS'(1) : COUNT_BITS'(interval_ff);
               rem_in  = '0;
               step_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (div_last) begin
               cur_width_in = stepped_width;
               num_in  = width_count_ff;
               // a zero width divides by one, so the pulse ends at once
               den_in  = (stepped_width == '0) ? COUNT_BITS'(1)
                                               : COUNT_BITS'(stepped_width);
               rem_in  = '0;
               step_in = '0;
               state_in = ST_WIDTH;
            end
         end
         ST_WIDTH: begin
            if (div_last) begin
               if (is_mult) begin
                  level_in        = 1'b0;
                  pulse_active_in = 1'b0;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.level     = level_ff;
               rsp_data_in.width_now = 10'(cur_width_ff);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         period_count_ff <= '0;
         width_count_ff  <= '0;
         sweep_count_ff  <= '0;
         pulse_active_ff <= 1'b0;
         cur_width_ff    <= WIDTH_BITS'(WIDTH_RESET);
         level_ff        <= 1'b0;
         first_tick_ff   <= 1'b1;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         period_count_ff <= period_count_in;
         width_count_ff  <= width_count_in;
         sweep_count_ff  <= sweep_count_in;
         pulse_active_ff <= pulse_active_in;
         cur_width_ff    <= cur_width_in;
         level_ff        <= level_in;
         first_tick_ff   <= first_tick_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      interval_ff <= interval_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted tick always starts with the period test
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_PERIOD && step_ff == '0))
      else $error("accepted tick did not start the period test");

   // running remainder stays below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PERIOD || state_ff == ST_SWEEP || state_ff == ST_WIDTH)
      |-> (den_ff != '0 && rem_ff < den_ff))
      else $error("remainder unit out of range");

   // a result word only appears out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish state");

   // the pulse flag and the level agree once a tick is done
   a_level_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (level_ff == pulse_active_ff))
      else $error("level and pulse flag disagree");

endmodule
